@@ rtl/pmpe_pkg.sv @@
package pmpe_pkg;

   // Fixed field widths
   localparam int ANGLE_BITS = 16;
   localparam int COORD_BITS = 16;
   localparam int CFG_W = 5;
   localparam int MATCH_W = 7;
   localparam int MATCH_MAX = 32;
   localparam int DEF_MAX_DIRECTIONS = 16;

   // Stream payload widths
   localparam int REQ_DATA_W = 6 * COORD_BITS;
   localparam int RSP_DATA_W = 24;

   // Register map
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_DIR_COUNT = 1'b0;
   localparam logic [CFG_W-1:0] DIR_COUNT_RESET = 5'd4;

   // CORDIC vectoring, angles in units of 2^-32 turn
   localparam int CORDIC_STEPS = 30;
   localparam int STEP_W = 5;
   localparam int LANE_W = 34;
   localparam logic [31:0] CORDIC_TAB [CORDIC_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1};

   typedef logic signed [ANGLE_BITS-1:0] angle_type;

   // Item handed from the angle front end to the matching back end
   typedef struct packed {
      logic      boundary;
      angle_type conn;
      angle_type dst;
      angle_type src;
   } entry_type;

   localparam int QUEUE_DEPTH = 2;

   // Step commands shared by the three CORDIC lanes
   typedef struct packed {
      logic              load;
      logic              norm;
      logic              rot;
      logic [STEP_W-1:0] step;
   } lane_ctrl_type;

   // Arithmetic shift that truncates toward zero
   function automatic logic signed [LANE_W-1:0] shr_tz(
      input logic signed [LANE_W-1:0] v, input logic [STEP_W-1:0] s);
      logic signed [LANE_W-1:0] r;
      if (v[LANE_W-1]) begin
         r = -((-v) >>> s);
      end else begin
         r = v >>> s;
      end
      return r;
   endfunction

endpackage

@@ rtl/pmpe_ram.sv @@
module pmpe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/pmpe_cordic.sv @@
module pmpe_cordic (
   input  logic                                 clock,
   input  logic signed [pmpe_pkg::COORD_BITS-1:0] x_in,
   input  logic signed [pmpe_pkg::COORD_BITS-1:0] y_in,
   input  pmpe_pkg::lane_ctrl_type              ctrl,
   output logic                                 normd,
   output pmpe_pkg::angle_type                  angle
);
   import pmpe_pkg::*;

   localparam logic signed [LANE_W-1:0] LIM = LANE_W'(1) <<< 30;
   localparam logic signed [LANE_W-1:0] HALF_TURN = LANE_W'(1) <<< 31;
   localparam logic [32:0] RND = 33'd1 << (32 - ANGLE_BITS - 1);

   logic signed [LANE_W-1:0] x_ff, y_ff, z_ff;
   logic                     zero_ff;
   logic signed [LANE_W-1:0] xs, ys, dx, dy;
   logic [32:0]              rounded;

   assign xs = LANE_W'(x_in);
   assign ys = LANE_W'(y_in);
   assign dx = shr_tz(y_ff, ctrl.step);
   assign dy = shr_tz(x_ff, ctrl.step);

   // Normalised once a component reaches 2^30
   assign normd = zero_ff || (x_ff >= LIM) || (y_ff >= LIM) || (y_ff <= -LIM);

   // Round half up to the angle width
   assign rounded = {1'b0, z_ff[31:0]} + RND;
   assign angle = zero_ff ? '0 : angle_type'(rounded[31 -: ANGLE_BITS]);

   // Load, double, then rotate one step a cycle
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         zero_ff <= (x_in == '0) && (y_in == '0);
         if (x_in[COORD_BITS-1]) begin
            x_ff <= -xs;
            y_ff <= -ys;
            z_ff <= HALF_TURN;
         end else begin
            x_ff <= xs;
            y_ff <= ys;
            z_ff <= '0;
         end
      end else if (ctrl.norm && !normd) begin
         x_ff <= x_ff <<< 1;
         y_ff <= y_ff <<< 1;
      end else if (ctrl.rot) begin
         if (y_ff > 0) begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + LANE_W'(CORDIC_TAB[ctrl.step]);
         end else begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - LANE_W'(CORDIC_TAB[ctrl.step]);
         end
      end
   end

endmodule

@@ rtl/pmpe_queue.sv @@
module pmpe_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pmpe_pkg::entry_type wr_data,
   output logic                full,
   input  logic                pop,
   output logic                rd_valid,
   output pmpe_pkg::entry_type rd_data
);
   import pmpe_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];

   // Store pushed beats
   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push && !full) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop && rd_valid) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CNT_W'(push && !full) - CNT_W'(pop && rd_valid);
      end
   end

endmodule

@@ rtl/pmpe_front.sv @@
module pmpe_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pmpe_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tuser,
   input  logic                              q_full,
   output logic                              q_push,
   output pmpe_pkg::entry_type               q_wdata
);
   import pmpe_pkg::*;

   typedef enum logic [1:0] {F_IDLE, F_NORM, F_ROT, F_PUSH} state_type;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic              bnd_ff;
   lane_ctrl_type     ctrl;
   logic              accept;
   logic [2:0]        normd;
   angle_type         ang_src, ang_dst, ang_conn;

   assign req_tready = (state_ff == F_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign ctrl.load = accept;
   assign ctrl.norm = (state_ff == F_NORM);
   assign ctrl.rot  = (state_ff == F_ROT);
   assign ctrl.step = step_ff;

   pmpe_cordic u_src (
      .clock (clock),
      .x_in  (req_tdata[0*COORD_BITS +: COORD_BITS]),
      .y_in  (req_tdata[1*COORD_BITS +: COORD_BITS]),
      .ctrl  (ctrl),
      .normd (normd[0]),
      .angle (ang_src)
   );

   pmpe_cordic u_dst (
      .clock (clock),
      .x_in  (req_tdata[2*COORD_BITS +: COORD_BITS]),
      .y_in  (req_tdata[3*COORD_BITS +: COORD_BITS]),
      .ctrl  (ctrl),
      .normd (normd[1]),
      .angle (ang_dst)
   );

   pmpe_cordic u_conn (
      .clock (clock),
      .x_in  (req_tdata[4*COORD_BITS +: COORD_BITS]),
      .y_in  (req_tdata[5*COORD_BITS +: COORD_BITS]),
      .ctrl  (ctrl),
      .normd (normd[2]),
      .angle (ang_conn)
   );

   assign q_push           = (state_ff == F_PUSH) && !q_full;
   assign q_wdata.boundary = bnd_ff;
   assign q_wdata.src      = ang_src;
   assign q_wdata.dst      = ang_dst;
   assign q_wdata.conn     = ang_conn;

   // Sequence: accept, normalise, rotate, hand over; a boundary beat goes straight to hand over
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= '0;
         bnd_ff   <= 1'b0;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (accept) begin
                  bnd_ff   <= req_tuser;
                  state_ff <= req_tuser ? F_PUSH : F_NORM;
               end
            end
            F_NORM: begin
               if (&normd) begin
                  step_ff  <= '0;
                  state_ff <= F_ROT;
               end
            end
            F_ROT: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
                  state_ff <= F_PUSH;
               end
            end
            F_PUSH: begin
               if (!q_full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

@@ rtl/pmpe_back.sv @@
module pmpe_back #(
   parameter int MAX_DIRECTIONS = pmpe_pkg::DEF_MAX_DIRECTIONS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [pmpe_pkg::CFG_W-1:0]      dir_count,
   input  logic                            q_valid,
   input  pmpe_pkg::entry_type             q_data,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pmpe_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tuser
);
   import pmpe_pkg::*;

   localparam int IDX_W = (MAX_DIRECTIONS > 1) ? $clog2(MAX_DIRECTIONS) : 1;
   localparam int CNT_W = $clog2(MAX_DIRECTIONS + 1);
   localparam int NW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int SUM_W = ANGLE_BITS + IDX_W + 1;
   localparam int DW    = SUM_W + 1;
   localparam logic [MATCH_W-1:0] MATCH_BND = '1;

   typedef enum logic [1:0] {B_TAKE, B_PASS, B_DRAIN, B_FIN} state_type;

   state_type               state_ff;
   logic [CNT_W-1:0]        cnt_ff, n_ff, t_ff;
   logic [IDX_W-1:0]        best_idx_ff;
   angle_type               eff_ff, best_rot_ff, f0_ff, clast_ff;
   logic                    pend_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic                    rsp_valid_ff, rsp_bnd_ff;
   angle_type               rsp_eff_ff;
   logic [MATCH_W-1:0]      rsp_match_ff;

   logic [NW-1:0]           cfg_n;
   logic [CNT_W-1:0]        nn, j, cnt_next;
   logic [CNT_W:0]          tk, tk_mod;
   angle_type               term, f0v, rot, src_rd, dst_rd, pterm;
   logic [ANGLE_BITS:0]     rot_mag, best_mag;
   logic                    better, last;
   logic signed [DW-1:0]    diff;
   logic [DW-1:0]           dm, qv;
   logic signed [DW:0]      mv;
   logic [MATCH_W-1:0]      match;

   // Clamp the direction count to 1..MAX_DIRECTIONS
   always_comb begin
      cfg_n = NW'(dir_count);
      if (cfg_n == '0) begin
         nn = CNT_W'(1);
      end else if (cfg_n > NW'(MAX_DIRECTIONS)) begin
         nn = CNT_W'(MAX_DIRECTIONS);
      end else begin
         nn = CNT_W'(cfg_n);
      end
   end

   // Per-item update of effort and best rotation
   always_comb begin
      j        = (cnt_ff >= nn) ? '0 : cnt_ff;
      term     = q_data.dst - q_data.src - q_data.conn;
      f0v      = (j == '0) ? q_data.src : f0_ff;
      rot      = q_data.dst - f0v - q_data.conn;
      rot_mag  = rot[ANGLE_BITS-1] ? -{rot[ANGLE_BITS-1], rot} : {1'b0, rot};
      best_mag = best_rot_ff[ANGLE_BITS-1] ? -{best_rot_ff[ANGLE_BITS-1], best_rot_ff}
                                           : {1'b0, best_rot_ff};
      better   = (j == '0) || (rot_mag < best_mag);
      cnt_next = j + 1'b1;
      last     = (cnt_next >= nn);
   end

   assign q_pop = (state_ff == B_TAKE) && q_valid && !rsp_valid_ff;

   // Rotated target index for the matching pass
   always_comb begin
      tk     = (CNT_W + 1)'(t_ff) + (CNT_W + 1)'(best_idx_ff);
      tk_mod = (tk >= (CNT_W + 1)'(n_ff)) ? tk - (CNT_W + 1)'(n_ff) : tk;
   end

   pmpe_ram #(.WIDTH(ANGLE_BITS), .DEPTH(1 << IDX_W)) u_src_store (
      .clock   (clock),
      .wr_en   (q_pop && !q_data.boundary),
      .wr_addr (j[IDX_W-1:0]),
      .wr_data (q_data.src),
      .rd_addr (t_ff[IDX_W-1:0]),
      .rd_data (src_rd)
   );

   pmpe_ram #(.WIDTH(ANGLE_BITS), .DEPTH(1 << IDX_W)) u_dst_store (
      .clock   (clock),
      .wr_en   (q_pop && !q_data.boundary),
      .wr_addr (j[IDX_W-1:0]),
      .wr_data (q_data.dst),
      .rd_addr (tk_mod[IDX_W-1:0]),
      .rd_data (dst_rd)
   );

   assign pterm = dst_rd - src_rd - clast_ff;

   // Final matching: round half away, saturate
   always_comb begin
      diff = DW'(sum_ff) - DW'(eff_ff);
      dm   = diff[DW-1] ? DW'(-diff) : DW'(diff);
      qv   = (dm + (DW'(1) << (ANGLE_BITS - 1))) >> ANGLE_BITS;
      // A negative difference rounds to a negative quotient
      if (diff[DW-1]) begin
         mv = $signed((DW + 1)'(best_idx_ff)) + $signed({1'b0, qv});
      end else begin
         mv = $signed((DW + 1)'(best_idx_ff)) - $signed({1'b0, qv});
      end
      if (mv > $signed((DW + 1)'(MATCH_MAX))) begin
         match = MATCH_W'(MATCH_MAX);
      end else if (mv < -$signed((DW + 1)'(MATCH_MAX))) begin
         match = MATCH_W'(-MATCH_MAX);
      end else begin
         match = mv[MATCH_W-1:0];
      end
   end

   // Take items, walk the stores, drive the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_TAKE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            B_TAKE: begin
               if (q_pop) begin
                  if (q_data.boundary) begin
                     cnt_ff       <= '0;
                     rsp_valid_ff <= 1'b1;
                     rsp_bnd_ff   <= 1'b1;
                     rsp_eff_ff   <= '0;
                     rsp_match_ff <= MATCH_BND;
                  end else begin
                     eff_ff <= (j == '0) ? term : eff_ff + term;
                     if (j == '0) begin
                        f0_ff <= q_data.src;
                     end
                     if (better) begin
                        best_rot_ff <= rot;
                        best_idx_ff <= j[IDX_W-1:0];
                     end
                     if (last) begin
                        cnt_ff   <= '0;
                        n_ff     <= nn;
                        t_ff     <= '0;
                        clast_ff <= q_data.conn;
                        sum_ff   <= '0;
                        pend_ff  <= 1'b0;
                        state_ff <= B_PASS;
                     end else begin
                        cnt_ff <= cnt_next;
                     end
                  end
               end
            end
            B_PASS: begin
               pend_ff <= 1'b1;
               if (pend_ff) begin
                  sum_ff <= sum_ff + SUM_W'(pterm);
               end
               t_ff <= t_ff + 1'b1;
               if (t_ff == n_ff - 1'b1) begin
                  state_ff <= B_DRAIN;
               end
            end
            B_DRAIN: begin
               sum_ff   <= sum_ff + SUM_W'(pterm);
               state_ff <= B_FIN;
            end
            B_FIN: begin
               rsp_valid_ff <= 1'b1;
               rsp_bnd_ff   <= 1'b0;
               rsp_eff_ff   <= eff_ff;
               rsp_match_ff <= match;
               state_ff     <= B_TAKE;
            end
            default: state_ff <= B_TAKE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_bnd_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_match_ff, rsp_eff_ff});

   a_pass_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_PASS |-> t_ff < n_ff)
      else $error("matching pass index beyond direction count");

   a_pop_slot_free: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !rsp_valid_ff)
      else $error("item taken while result register occupied");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_DIRECTIONS))
      else $error("direction counter beyond maximum");

   a_fin_emits: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_FIN |=> rsp_valid_ff)
      else $error("matching result not presented");

endmodule

@@ rtl/principal_matching_per_edge.sv @@
// Channel  Ports        Beat contents
// req      req_t*       tdata: src_x, src_y, dst_x, dst_y, conn_re, conn_im; tuser: boundary
// rsp      rsp_t*       tdata: effort_angle, matching_shift; tuser: is_boundary
// csr      csr_p*       direction_count at byte address 0
//
// A non-boundary beat is loaded, normalised and taken through 30 CORDIC steps in three
// parallel lanes, then handed into the queue.
// The last beat of an edge adds a walk over the N stored angle pairs.
// A boundary beat skips the angle lanes.
// Reset is synchronous and clears control state; the angle stores need no clearing.
// A stalled result holds the back end; the front end keeps accepting into the queue until it is full.
module principal_matching_per_edge #(
   parameter int MAX_DIRECTIONS = pmpe_pkg::DEF_MAX_DIRECTIONS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // src_x, src_y, dst_x, dst_y, conn_re, conn_im
   input  logic [pmpe_pkg::REQ_DATA_W-1:0] req_tdata,
   // boundary
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // effort_angle, matching_shift, one zero pad bit
   output logic [pmpe_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // is_boundary
   output logic                            rsp_tuser,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pmpe_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import pmpe_pkg::*;

   logic [CFG_W-1:0] dir_count_ff;
   logic             q_push, q_full, q_pop, q_valid;
   entry_type        q_wdata, q_rdata;

   // Register file
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_DIR_COUNT) ? 32'(dir_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_count_ff <= DIR_COUNT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == REG_DIR_COUNT) begin
         dir_count_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   pmpe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_wdata    (q_wdata)
   );

   pmpe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wr_data  (q_wdata),
      .full     (q_full),
      .pop      (q_pop),
      .rd_valid (q_valid),
      .rd_data  (q_rdata)
   );

   pmpe_back #(.MAX_DIRECTIONS(MAX_DIRECTIONS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .dir_count  (dir_count_ff),
      .q_valid    (q_valid),
      .q_data     (q_rdata),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ tb/principal_matching_per_edge_tb.sv @@
module principal_matching_per_edge_tb;
   import pmpe_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 150;
   localparam int MAX_DIRS = DEF_MAX_DIRECTIONS;

   typedef struct packed {
      logic        boundary;
      logic [15:0] conn_im;
      logic [15:0] conn_re;
      logic [15:0] dst_y;
      logic [15:0] dst_x;
      logic [15:0] src_y;
      logic [15:0] src_x;
   } edge_beat_type;

   typedef struct packed {
      logic              is_boundary;
      logic [MATCH_W-1:0] matching_shift;
      angle_type         effort_angle;
   } match_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   edge_beat_type    beat_queue[$];
   match_result_type expected_matches[$];
   int               fail_count;
   int               idle_cycles;
   bit               gaps_on;
   int               req_gap;
   int               rsp_gap;

   // Mirror of the block state
   logic [CFG_W-1:0] dir_count;
   angle_type        src_angles[MAX_DIRS];
   angle_type        dst_angles[MAX_DIRS];
   int               dir_pos;
   angle_type        effort_acc;
   angle_type        best_rot;
   int               best_idx;

   principal_matching_per_edge DUT (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint trunc_shift(longint v, int s);
      if (v >= 0) return v >>> s;
      return -((-v) >>> s);
   endfunction

   // Binary angle of a vector by CORDIC vectoring
   function automatic angle_type vector_angle(logic signed [15:0] xs, logic signed [15:0] ys);
      longint x, y, z, dx, dy;
      longint unsigned u;
      x = xs;
      y = ys;
      z = 0;
      if (x == 0 && y == 0) return '0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 64'sd1 << 31;
      end
      while (x < (64'sd1 << 30) && y < (64'sd1 << 30) && y > -(64'sd1 << 30)) begin
         x = x * 2;
         y = y * 2;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = trunc_shift(y, i);
         dy = trunc_shift(x, i);
         if (y > 0) begin
            x += dx; y -= dy; z += longint'(CORDIC_TAB[i]);
         end else begin
            x -= dx; y += dy; z -= longint'(CORDIC_TAB[i]);
         end
      end
      u = longint'(z) & 64'hFFFF_FFFF;
      u = (u + 64'd32768) >> 16;
      return angle_type'(u[15:0]);
   endfunction

   function automatic int abs_int(int v);
      return v < 0 ? -v : v;
   endfunction

   // Update the mirrored edge state with one accepted beat
   task automatic predict_matching(edge_beat_type b);
      int n, j, sum, diff, q, m, gi;
      angle_type f, g, c, rot;
      match_result_type r;
      n = dir_count;
      if (n == 0) n = 1;
      if (n > MAX_DIRS) n = MAX_DIRS;
      if (b.boundary) begin
         dir_pos = 0;
         r.effort_angle = '0;
         r.matching_shift = -7'sd1;
         r.is_boundary = 1'b1;
         expected_matches = {expected_matches, r};
         return;
      end
      if (dir_pos >= n) dir_pos = 0;
      j = dir_pos;
      f = vector_angle(b.src_x, b.src_y);
      g = vector_angle(b.dst_x, b.dst_y);
      c = vector_angle(b.conn_re, b.conn_im);
      src_angles[j] = f;
      dst_angles[j] = g;
      if (j == 0) effort_acc = angle_type'(g - f - c);
      else effort_acc = angle_type'(effort_acc + g - f - c);
      rot = angle_type'(g - src_angles[0] - c);
      if (j == 0 || abs_int(rot) < abs_int(best_rot)) begin
         best_rot = rot;
         best_idx = j;
      end
      dir_pos = j + 1;
      if (dir_pos < n) return;
      dir_pos = 0;
      sum = 0;
      for (int t = 0; t < n; t++) begin
         gi = (t + best_idx) % n;
         sum += int'(angle_type'(dst_angles[gi] - src_angles[t] - c));
      end
      diff = sum - int'(effort_acc);
      q = (abs_int(diff) + 32768) >>> 16;
      if (diff < 0) q = -q;
      m = best_idx - q;
      if (m > MATCH_MAX) m = MATCH_MAX;
      if (m < -MATCH_MAX) m = -MATCH_MAX;
      r.effort_angle = effort_acc;
      r.matching_shift = m[MATCH_W-1:0];
      r.is_boundary = 1'b0;
      expected_matches = {expected_matches, r};
   endtask

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   function automatic logic [15:0] pick_coord();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4: return 16'(int'($urandom_range(0, 6)) - 3);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic edge_beat_type random_beat();
      edge_beat_type b;
      b.src_x = pick_coord();
      b.src_y = pick_coord();
      b.dst_x = pick_coord();
      b.dst_y = pick_coord();
      b.conn_re = pick_coord();
      b.conn_im = pick_coord();
      b.boundary = 1'b0;
      return b;
   endfunction

   function automatic edge_beat_type flat_beat(logic [15:0] v, logic bnd);
      edge_beat_type b;
      b = '{bnd, v, v, v, v, v, v};
      return b;
   endfunction

   // Input side: hold each beat until taken, then advance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) predict_matching({req_tuser, req_tdata});
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_tvalid <= 1'b0;
               req_gap <= req_gap - 1;
            end else if (beat_queue.size() > 0) begin
               edge_beat_type b;
               b = beat_queue.pop_front();
               req_tdata <= b[REQ_DATA_W-1:0];
               req_tuser <= b.boundary;
               req_tvalid <= 1'b1;
               req_gap <= pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result side: random stalls, compare every beat with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_matches.size() == 0) begin
               $error("unexpected result beat tdata=%h tuser=%b", rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               match_result_type e;
               e = expected_matches.pop_front();
               if (rsp_tdata[15:0] !== e.effort_angle) begin
                  $error("effort_angle expected %0d got %0d", e.effort_angle,
                         $signed(rsp_tdata[15:0]));
                  fail_count++;
               end
               if (rsp_tdata[22:16] !== e.matching_shift) begin
                  $error("matching_shift expected %0d got %0d", $signed(e.matching_shift),
                         $signed(rsp_tdata[22:16]));
                  fail_count++;
               end
               if (rsp_tuser !== e.is_boundary) begin
                  $error("is_boundary expected %0b got %0b", e.is_boundary, rsp_tuser);
                  fail_count++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_tready <= 1'b0;
            rsp_gap <= rsp_gap - 1;
         end else begin
            rsp_tready <= 1'b1;
            rsp_gap <= pick_gap();
         end
      end
   end

   // Watchdog on cycles without any accepted beat or register access
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic write_dir_count(logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(REG_DIR_COUNT) << 2;
      csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      dir_count = value;
   endtask

   task automatic drain();
      wait (beat_queue.size() == 0 && !req_tvalid && expected_matches.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Whole edges with random content, some broken by a boundary, a partial edge at the end
   task automatic queue_edges(int beats);
      int n, k, cut;
      edge_beat_type b;
      n = dir_count == 0 ? 1 : (dir_count > MAX_DIRS ? MAX_DIRS : dir_count);
      k = 0;
      while (k < beats) begin
         cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n;
         for (int i = 0; i < cut; i++) beat_queue = {beat_queue, random_beat()};
         k += cut;
         if (cut < n || $urandom_range(0, 19) == 0) begin
            b = random_beat();
            b.boundary = 1'b1;
            beat_queue = {beat_queue, b};
            k++;
         end
      end
      cut = $urandom_range(0, n - 1);
      for (int i = 0; i < cut; i++) beat_queue = {beat_queue, random_beat()};
   endtask

   initial begin
      logic [CFG_W-1:0] counts[$];
      edge_beat_type b;
      fail_count = 0;
      gaps_on = 1'b1;
      dir_count = DIR_COUNT_RESET;
      dir_pos = 0;
      effort_acc = '0;
      best_rot = '0;
      best_idx = 0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, zero vectors, pi, boundary alone and mid-edge
      beat_queue = {beat_queue, flat_beat(16'h8000, 1'b0)};
      beat_queue = {beat_queue, flat_beat(16'h7FFF, 1'b0)};
      beat_queue = {beat_queue, flat_beat(16'h0000, 1'b0)};
      beat_queue = {beat_queue, flat_beat(16'hFFFF, 1'b0)};
      b = '{1'b0, 16'h0000, 16'h8000, 16'h0000, 16'h8001, 16'h7FFF, 16'h0000};
      beat_queue = {beat_queue, b};
      b = '{1'b0, 16'h7FFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h0001, 16'h8000};
      beat_queue = {beat_queue, b};
      b = '{1'b0, 16'h5A82, 16'hA57E, 16'h0000, 16'h0001, 16'h8000, 16'h8000};
      beat_queue = {beat_queue, b};
      b = '{1'b0, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF};
      beat_queue = {beat_queue, b};
      beat_queue = {beat_queue, flat_beat(16'h1234, 1'b1)};
      beat_queue = {beat_queue, random_beat()};
      beat_queue = {beat_queue, random_beat()};
      beat_queue = {beat_queue, flat_beat(16'hFFFF, 1'b1)};
      for (int i = 0; i < 8; i++) beat_queue = {beat_queue, random_beat()};
      beat_queue = {beat_queue, random_beat()};
      drain();

      // Count settings, extremes among them; each phase may end with an edge left open
      counts = '{5'd1, 5'd0, 5'd16, 5'd31, 5'd2, 5'd4, 5'd3, 5'd17, 5'd7, 5'd1};
      for (int p = 0; p < 3; p++) counts = {counts, 5'($urandom_range(1, 16))};
      foreach (counts[p]) begin
         write_dir_count(counts[p]);
         gaps_on = (p % 4) != 3;
         queue_edges(110);
         drain();
      end

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
